[hw/rtl/rpn_pkg.sv]
// Shared types, constants and helper functions of the RPN stack calculator.
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;

   // sticky flag bit positions
   localparam int FLAG_UNDER = 0;
   localparam int FLAG_OVER  = 1;
   localparam int FLAG_DIVZ  = 2;
   localparam int FLAG_SAT   = 3;

   // CORDIC datapath width (Q2.30 with headroom) and step count
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 24;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // shared divider widths
   localparam int DVD_W = 50;
   localparam int DVS_W = 34;

   // angle constants in Q16.16
   localparam logic [19:0]        TWO_PI_U = 20'd411775;
   localparam logic signed [20:0] TWO_PI_S = 21'sd411775;
   localparam logic signed [20:0] PI_S     = 21'sd205887;
   localparam logic signed [20:0] HALF_PI_S = 21'sd102944;

   // reciprocal of 2pi for the angle modulo: quotient estimate is low by at most one
   localparam int          MOD_SHIFT = 50;
   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << MOD_SHIFT) / 64'(TWO_PI_U));

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_SIN  = 3'd5,
      OP_COS  = 3'd6,
      OP_TAN  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      DIV_QUO,
      DIV_TAN
   } div_kind_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_POPB,
      S_POPA_WAIT,
      S_POPA,
      S_EXEC,
      S_MUL_FIN,
      S_MOD_WAIT,
      S_TRIG_INIT,
      S_CORDIC,
      S_TRIG_FIN,
      S_TAN_DIV,
      S_QUO_WAIT,
      S_DIV_FIN,
      S_PUSH,
      S_EMIT_WAIT,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] number;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] answer;
      logic               underflow_seen;
      logic               overflow_seen;
      logic               divide_by_zero_seen;
      logic               saturation_seen;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic         load;
      logic         pop_b;
      logic         pop_a;
      logic         arith;
      logic         mul;
      logic         mul_fin;
      logic         mod_mul;
      logic         mod_sub;
      logic         div_start;
      div_kind_type div_kind;
      logic         div_fin;
      logic         trig_init;
      logic         cordic_step;
      logic         trig_fin;
      logic         set_divz;
      logic         push;
      logic         emit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      op_type op;
      logic   last;
      logic   b_zero;
      logic   div_busy;
      logic   cordic_last;
      logic   x_zero;
      logic   rsp_free;
   } stat_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } clamp_type;

   // clamp a wide signed value into Q16.16 range
   function automatic clamp_type clamp32(input logic signed [63:0] v);
      clamp_type r;
      if (v > 64'sd2147483647) begin
         r.sat = 1'b1;
         r.val = Q_MAX;
      end else if (v < -64'sd2147483648) begin
         r.sat = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.sat = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

   // arctangent table, Q2.30
   function automatic logic [CORDIC_W-1:0] atan_lookup(input logic [4:0] i);
      logic [CORDIC_W-1:0] r;
      unique case (i)
         5'd0:  r = 34'd843314857;
         5'd1:  r = 34'd497837829;
         5'd2:  r = 34'd263043837;
         5'd3:  r = 34'd133525159;
         5'd4:  r = 34'd67021687;
         5'd5:  r = 34'd33543516;
         5'd6:  r = 34'd16775851;
         5'd7:  r = 34'd8388437;
         5'd8:  r = 34'd4194283;
         5'd9:  r = 34'd2097149;
         5'd10: r = 34'd1048576;
         5'd11: r = 34'd524288;
         5'd12: r = 34'd262144;
         5'd13: r = 34'd131072;
         5'd14: r = 34'd65536;
         5'd15: r = 34'd32768;
         5'd16: r = 34'd16384;
         5'd17: r = 34'd8192;
         5'd18: r = 34'd4096;
         5'd19: r = 34'd2048;
         5'd20: r = 34'd1024;
         5'd21: r = 34'd512;
         5'd22: r = 34'd256;
         5'd23: r = 34'd128;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rpn_stack_calculator.sv]
// Top level of the RPN stack calculator: controller plus datapath.
//
//  channel | ports                          | word
//  --------+--------------------------------+---------------------------------
//  request | req_valid, req_stall, req_data | opcode, number, last
//  result  | rsp_valid, rsp_stall, rsp_data | answer and four sticky flags
//
// One token at a time. Div runs the 50-step restoring divider, then a check
// that it is idle; a zero divisor skips the divider. Sin/cos take the angle
// modulo by reciprocal multiply, then run 24 CORDIC steps. Tan runs the CORDIC,
// then the divider (not when the cosine is zero). A last token adds the final
// pop.
// Synchronous reset empties the stack and clears the flags; stack memory is
// not cleared. A stalled result word holds in its register; the block
// waits only when a new result is due while the previous one is still held.
`default_nettype none

module rpn_stack_calculator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   rpn_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   rpn_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[hw/rtl/rpn_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module rpn_div
   import rpn_pkg::*;
#(
   parameter int DW = DVD_W,
   parameter int SW = DVS_W
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [SW-1:0] divisor,
   output logic               busy,
   output logic [DW-1:0]      quotient
);

   localparam int CNT_W = $clog2(DW);

   logic [SW-1:0]    dvs_ff, dvs_in;
   logic [SW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [SW:0]      sh;
   logic [SW:0]      diff;

   // shift in one dividend bit and try the subtraction
   always_comb begin
      sh      = {rem_ff, quo_ff[DW-1]};
      diff    = sh - {1'b0, dvs_ff};
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, dvs_ff}) begin
            rem_in = diff[SW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = sh[SW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

[hw/rtl/rpn_datapath.sv]
// Datapath: operand stack, arithmetic, CORDIC, divider and result register.
`default_nettype none

module rpn_datapath
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   input  wire logic    rsp_stall,
   output stat_type     stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

   // token and operands
   op_type              op_ff, op_in;
   logic                last_ff, last_in;
   logic signed [31:0]  a_ff, a_in;
   logic signed [31:0]  b_ff, b_in;
   logic signed [31:0]  res_ff, res_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [3:0]          flags_ff, flags_in;
   logic [19:0]         modr_ff, modr_in;

   // CORDIC state
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic [4:0]                 iter_ff, iter_in;
   logic                       tneg_ff, tneg_in;
   logic                       qneg_ff, qneg_in;

   // result channel
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // stack memory and divider hookup
   logic                we;
   logic [ADDR_W-1:0]   raddr;
   logic [31:0]         rdata;
   logic [DVD_W-1:0]    dvd;
   logic [DVS_W-1:0]    dvs;
   logic                div_busy;
   logic [DVD_W-1:0]    quo;

   // helpers
   logic                        empty;
   logic signed [31:0]          popped;
   logic [31:0]                 a_mag, b_mag;
   logic [CORDIC_W-1:0]         x_mag, y_mag;
   clamp_type                   cl;
   logic signed [63:0]          qw;
   logic [33:0]                 mod_diff;
   logic [19:0]                 rmag;
   logic [19:0]                 r_u;
   logic signed [20:0]          rs;
   logic                        rneg;
   logic signed [CORDIC_W-1:0]  xs, ys, at, sel, v;
   logic                        rsp_free;

   assign raddr    = ADDR_W'(count_ff - 1'b1);
   assign empty    = (count_ff == '0);
   assign popped   = empty ? 32'sd0 : $signed(rdata);
   assign a_mag    = a_ff[31] ? (~a_ff + 1'b1) : a_ff;
   assign b_mag    = b_ff[31] ? (~b_ff + 1'b1) : b_ff;
   assign x_mag    = x_ff[CORDIC_W-1] ? (~x_ff + 1'b1) : x_ff;
   assign y_mag    = y_ff[CORDIC_W-1] ? (~y_ff + 1'b1) : y_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   rpn_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (res_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   rpn_div #(
      .DW (DVD_W),
      .SW (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dvs),
      .busy      (div_busy),
      .quotient  (quo)
   );

   // select divider operands
   always_comb begin
      unique case (cmd.div_kind)
         DIV_QUO: begin
            dvd = DVD_W'({a_mag, 16'b0});
            dvs = DVS_W'(b_mag);
         end
         DIV_TAN: begin
            dvd = DVD_W'({y_mag, 16'b0});
            dvs = DVS_W'(x_mag);
         end
         default: begin
            dvd = '0;
            dvs = '0;
         end
      endcase
   end

   // next state of the datapath registers
   always_comb begin
      op_in        = op_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      res_in       = res_ff;
      prod_in      = prod_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      modr_in      = modr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      iter_in      = iter_ff;
      tneg_in      = tneg_ff;
      qneg_in      = qneg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      we           = 1'b0;
      cl           = clamp32(64'sd0);
      qw           = 64'sd0;
      mod_diff     = '0;
      rmag         = '0;
      r_u          = '0;
      rs           = '0;
      rneg         = 1'b0;
      xs           = x_ff >>> iter_ff;
      ys           = y_ff >>> iter_ff;
      at           = $signed(atan_lookup(iter_ff));
      sel          = (op_ff == OP_SIN) ? y_ff : x_ff;
      v            = (sel + CORDIC_W'(8192)) >>> 14;

      // latch the token
      if (cmd.load) begin
         op_in   = op_type'(req_data.opcode);
         last_in = req_data.last;
         res_in  = req_data.number;
      end

      // pop operands, zero on an empty stack
      if (cmd.pop_b || cmd.pop_a) begin
         if (empty) begin
            flags_in[FLAG_UNDER] = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
         if (cmd.pop_b) begin
            b_in = popped;
         end else begin
            a_in = popped;
         end
      end

      // add and subtract with clamp
      if (cmd.arith) begin
         if (op_ff == OP_SUB) begin
            cl = clamp32(64'(a_ff) - 64'(b_ff));
         end else begin
            cl = clamp32(64'(a_ff) + 64'(b_ff));
         end
         res_in = cl.val;
         flags_in[FLAG_SAT] = flags_ff[FLAG_SAT] | cl.sat;
      end

      // multiply, then floor shift and clamp
      if (cmd.mul) begin
         prod_in = a_ff * b_ff;
      end
      if (cmd.mul_fin) begin
         cl = clamp32(prod_ff >>> 16);
         res_in = cl.val;
         flags_in[FLAG_SAT] = flags_ff[FLAG_SAT] | cl.sat;
      end

      // angle magnitude modulo 2pi: estimate the quotient by reciprocal
      if (cmd.mod_mul) begin
         prod_in = $signed(64'(a_mag) * 64'(MOD_RECIP));
      end
      // subtract the estimate; the remainder is left below twice 2pi
      if (cmd.mod_sub) begin
         mod_diff = 34'(a_mag) - 34'(prod_ff[63:MOD_SHIFT]) * 34'(TWO_PI_U);
         modr_in  = mod_diff[19:0];
      end

      // remember the quotient sign at start
      if (cmd.div_start) begin
         if (cmd.div_kind == DIV_TAN) begin
            qneg_in = y_ff[CORDIC_W-1] ^ x_ff[CORDIC_W-1];
         end else begin
            qneg_in = a_ff[31] ^ b_ff[31];
         end
      end
      if (cmd.div_fin) begin
         qw = $signed({14'b0, quo});
         cl = clamp32(qneg_ff ? -qw : qw);
         res_in = cl.val;
         flags_in[FLAG_SAT] = flags_ff[FLAG_SAT] | cl.sat;
      end

      // reduce the angle and seed the CORDIC
      if (cmd.trig_init) begin
         rmag = (modr_ff >= TWO_PI_U) ? (modr_ff - TWO_PI_U) : modr_ff;
         r_u  = (a_ff[31] && (rmag != '0)) ? (TWO_PI_U - rmag) : rmag;
         rs   = $signed({1'b0, r_u});
         if (rs > PI_S) begin
            rs = rs - TWO_PI_S;
         end
         if (rs > HALF_PI_S) begin
            rs   = rs - PI_S;
            rneg = 1'b1;
         end else if (rs < -HALF_PI_S) begin
            rs   = rs + PI_S;
            rneg = 1'b1;
         end
         z_in    = CORDIC_W'(rs) <<< 14;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         iter_in = '0;
         tneg_in = rneg;
      end

      // one rotation step
      if (cmd.cordic_step) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
      end

      // sin and cos rounding, tan with zero cosine
      if (cmd.trig_fin) begin
         if (op_ff == OP_TAN) begin
            res_in = y_ff[CORDIC_W-1] ? Q_MIN : Q_MAX;
            flags_in[FLAG_SAT] = 1'b1;
         end else begin
            res_in = tneg_ff ? 32'(-v) : 32'(v);
         end
      end

      if (cmd.set_divz) begin
         flags_in[FLAG_DIVZ] = 1'b1;
      end

      // push, drop when full
      if (cmd.push) begin
         if (count_ff == DEPTH_C) begin
            flags_in[FLAG_OVER] = 1'b1;
         end else begin
            we       = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end

      // final pop: load the result word, clear stack and flags
      if (cmd.emit) begin
         rsp_in.answer              = popped;
         rsp_in.underflow_seen      = flags_ff[FLAG_UNDER] | empty;
         rsp_in.overflow_seen       = flags_ff[FLAG_OVER];
         rsp_in.divide_by_zero_seen = flags_ff[FLAG_DIVZ];
         rsp_in.saturation_seen     = flags_ff[FLAG_SAT];
         rsp_valid_in = 1'b1;
         count_in     = '0;
         flags_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_PUSH;
         last_ff      <= 1'b0;
         iter_ff      <= '0;
      end else begin
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         last_ff      <= last_in;
         iter_ff      <= iter_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      prod_ff <= prod_in;
      modr_ff <= modr_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      tneg_ff <= tneg_in;
      qneg_ff <= qneg_in;
      rsp_ff  <= rsp_in;
   end

   assign stat.op          = op_ff;
   assign stat.last        = last_ff;
   assign stat.b_zero      = (b_ff == 32'sd0);
   assign stat.div_busy    = div_busy;
   assign stat.cordic_last = (iter_ff == 5'(CORDIC_STEPS - 1));
   assign stat.x_zero      = (x_ff == '0);
   assign stat.rsp_free    = rsp_free;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule

`default_nettype wire

[hw/rtl/rpn_control.sv]
// Controller state machine sequencing each token through the datapath.
`default_nettype none

module rpn_control
   import rpn_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire stat_type stat,
   output logic          req_stall,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.div_kind = DIV_QUO;
      req_stall    = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.op)
               OP_PUSH:                       state_in = S_PUSH;
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_in = S_POPB;
               default:                       state_in = S_POPA;
            endcase
         end
         S_POPB: begin
            cmd.pop_b = 1'b1;
            state_in  = S_POPA_WAIT;
         end
         S_POPA_WAIT: begin
            state_in = S_POPA;
         end
         S_POPA: begin
            cmd.pop_a = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.op)
               OP_ADD, OP_SUB: begin
                  cmd.arith = 1'b1;
                  state_in  = S_PUSH;
               end
               OP_MUL: begin
                  cmd.mul  = 1'b1;
                  state_in = S_MUL_FIN;
               end
               OP_DIV: begin
                  if (stat.b_zero) begin
                     cmd.set_divz = 1'b1;
                     state_in     = stat.last ? S_EMIT_WAIT : S_IDLE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_QUO_WAIT;
                  end
               end
               default: begin
                  cmd.mod_mul = 1'b1;
                  state_in    = S_MOD_WAIT;
               end
            endcase
         end
         S_MUL_FIN: begin
            cmd.mul_fin = 1'b1;
            state_in    = S_PUSH;
         end
         S_MOD_WAIT: begin
            cmd.mod_sub = 1'b1;
            state_in    = S_TRIG_INIT;
         end
         S_TRIG_INIT: begin
            cmd.trig_init = 1'b1;
            state_in      = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (stat.cordic_last) begin
               state_in = S_TRIG_FIN;
            end
         end
         S_TRIG_FIN: begin
            if (stat.op == OP_TAN && !stat.x_zero) begin
               state_in = S_TAN_DIV;
            end else begin
               cmd.trig_fin = 1'b1;
               state_in     = S_PUSH;
            end
         end
         S_TAN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_kind  = DIV_TAN;
            state_in      = S_QUO_WAIT;
         end
         S_QUO_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_DIV_FIN;
            end
         end
         S_DIV_FIN: begin
            cmd.div_fin = 1'b1;
            state_in    = S_PUSH;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = stat.last ? S_EMIT_WAIT : S_IDLE;
         end
         S_EMIT_WAIT: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
